// File: sv/a4ls_pkg.sv
`timescale 1ns / 1ps
// Shared types for the 4-bit ADPCM look-ahead search encoder.
// No dependencies; imported by the node unit and the top level.
package a4ls_pkg;

    localparam int ERR_W  = 18;
    localparam int CODE_W = 4;

    localparam logic [CODE_W-1:0] CODE_MAX = 4'hf;

    // Decoder state and running squared error after one search level
    typedef struct packed {
        logic [7:0]       pred;
        logic [3:0]       step;
        logic [ERR_W-1:0] err;
    } t_lvl_state;

    // One search node: parent state, trial code and the sample it must match
    typedef struct packed {
        t_lvl_state        parent;
        logic [CODE_W-1:0] code;
        logic [7:0]        target;
    } t_node_req;

endpackage

// File: sv/a4ls_node.sv
`timescale 1ns / 1ps
// Shared node unit: decodes one trial code from a parent state and adds its squared error.
// Depends on a4ls_pkg.
module a4ls_node import a4ls_pkg::*; (
    input  t_node_req  i_req,
    output t_lvl_state o_res
);

    always_comb begin
        logic [2:0]  mag;
        logic [5:0]  scaled;
        logic [5:0]  delta;
        logic [8:0]  sum;
        logic [7:0]  pred_n;
        logic [3:0]  step_n;
        logic [7:0]  diff;
        logic [15:0] sq;

        mag = i_req.code[2:0];
        // step only ever holds 1, 2, 4 or 8
        case (i_req.parent.step)
            4'd2:    scaled = 6'(mag) << 1;
            4'd4:    scaled = 6'(mag) << 2;
            4'd8:    scaled = 6'(mag) << 3;
            default: scaled = 6'(mag);
        endcase
        delta = scaled + 6'(i_req.parent.step >> 1);

        sum = {1'b0, i_req.parent.pred} + 9'(delta);
        if (i_req.code[3]) begin
            pred_n = (i_req.parent.pred > 8'(delta)) ? (i_req.parent.pred - 8'(delta)) : 8'd0;
        end else begin
            pred_n = sum[8] ? 8'hff : sum[7:0];
        end

        if (mag == 3'd0 && i_req.parent.step > 4'd1) begin
            step_n = i_req.parent.step >> 1;
        end else if (mag >= 3'd5 && i_req.parent.step < 4'd8) begin
            step_n = i_req.parent.step << 1;
        end else begin
            step_n = i_req.parent.step;
        end

        diff = (pred_n > i_req.target) ? (pred_n - i_req.target) : (i_req.target - pred_n);
        sq   = diff * diff;

        o_res.pred = pred_n;
        o_res.step = step_n;
        o_res.err  = i_req.parent.err + ERR_W'(sq);
    end

endmodule

// File: sv/adpcm4_lookahead_search_encoder_unit.sv
`timescale 1ns / 1ps
// Header sample: its result is presented in the cycle after the sample is taken.
// Sample that does not complete a block: stored, no result.
// Completing sample: depth-first search, one node per cycle through the shared node unit,
// 16 + ... + 16^d nodes (16, 272, 4368, 69904 for d = 1..4), then the d best codes are emitted in order.
// Reset (synchronous, active low): depth 2, predictor 0, step 1, fill 0, output empty.
module adpcm4_lookahead_search_encoder_unit import a4ls_pkg::*; #(
    parameter int MAX_LOOKAHEAD = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sample,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_value,
    output logic        o_is_header,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LVL_W = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int DEP_W = $clog2(MAX_LOOKAHEAD + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_depth, n_depth;
    logic [7:0]        r_pred, n_pred;
    logic [3:0]        r_step, n_step;
    logic [DEP_W-1:0]  r_fill, n_fill;
    logic [DEP_W-1:0]  r_dep, n_dep;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [LVL_W-1:0]  r_emit_k, n_emit_k;
    logic [7:0]        r_samples [MAX_LOOKAHEAD];
    logic [7:0]        n_samples [MAX_LOOKAHEAD];
    logic [CODE_W-1:0] r_code [MAX_LOOKAHEAD];
    logic [CODE_W-1:0] n_code [MAX_LOOKAHEAD];
    t_lvl_state        r_lvl_st [MAX_LOOKAHEAD];
    t_lvl_state        n_lvl_st [MAX_LOOKAHEAD];
    logic [CODE_W-1:0] r_best_code [MAX_LOOKAHEAD];
    logic [CODE_W-1:0] n_best_code [MAX_LOOKAHEAD];
    logic [ERR_W-1:0]  r_best_err, n_best_err;
    logic [7:0]        r_best_pred, n_best_pred;
    logic [3:0]        r_best_step, n_best_step;
    logic              r_ov, n_ov;
    logic [7:0]        r_val, n_val;
    logic              r_hdr, n_hdr;
    logic              r_last, n_last;

    logic             out_free;
    logic             in_acc;
    logic             cfg_wr;
    logic [DEP_W-1:0] eff_dep;
    logic             at_leaf;
    logic             emit_last;
    logic             bt_found;
    logic [LVL_W-1:0] bt_lvl;
    t_node_req        node_req;
    t_lvl_state       node_res;

    a4ls_node u_node (
        .i_req (node_req),
        .o_res (node_res)
    );

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && !paddr[2];

    assign o_out_valid = r_ov;
    assign o_value     = r_val;
    assign o_is_header = r_hdr;
    assign o_last      = r_last;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : {29'd0, r_depth};

    always_comb begin
        if (r_depth == 3'd0) begin
            eff_dep = DEP_W'(1);
        end else if (r_depth > 3'(MAX_LOOKAHEAD)) begin
            eff_dep = DEP_W'(MAX_LOOKAHEAD);
        end else begin
            eff_dep = DEP_W'(r_depth);
        end
    end

    assign at_leaf   = (DEP_W'(r_lvl) == (r_dep - DEP_W'(1)));
    assign emit_last = (DEP_W'(r_emit_k) == (r_dep - DEP_W'(1)));

    always_comb begin
        if (r_lvl == '0) begin
            node_req.parent.pred = r_pred;
            node_req.parent.step = r_step;
            node_req.parent.err  = '0;
        end else begin
            node_req.parent = r_lvl_st[r_lvl - LVL_W'(1)];
        end
        node_req.code   = r_code[r_lvl];
        node_req.target = r_samples[r_lvl];
    end

    // deepest shallower level that still has codes left
    always_comb begin
        bt_found = 1'b0;
        bt_lvl   = '0;
        for (int j = 0; j < MAX_LOOKAHEAD; j++) begin
            if (LVL_W'(j) < r_lvl && r_code[j] != CODE_MAX) begin
                bt_found = 1'b1;
                bt_lvl   = LVL_W'(j);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_pred      = r_pred;
        n_step      = r_step;
        n_fill      = r_fill;
        n_dep       = r_dep;
        n_lvl       = r_lvl;
        n_emit_k    = r_emit_k;
        n_samples   = r_samples;
        n_code      = r_code;
        n_lvl_st    = r_lvl_st;
        n_best_code = r_best_code;
        n_best_err  = r_best_err;
        n_best_pred = r_best_pred;
        n_best_step = r_best_step;
        n_ov        = r_ov;
        n_val       = r_val;
        n_hdr       = r_hdr;
        n_last      = r_last;

        if (cfg_wr) begin
            n_depth = pwdata[2:0];
        end
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_first) begin
                        n_pred = i_sample;
                        n_step = 4'd1;
                        n_fill = '0;
                        n_ov   = 1'b1;
                        n_val  = i_sample;
                        n_hdr  = 1'b1;
                        n_last = 1'b1;
                    end else begin
                        n_samples[r_fill[LVL_W-1:0]] = i_sample;
                        if ((r_fill + DEP_W'(1)) >= eff_dep) begin
                            n_fill     = '0;
                            n_dep      = eff_dep;
                            n_lvl      = '0;
                            n_best_err = '1;
                            for (int i = 0; i < MAX_LOOKAHEAD; i++) begin
                                n_code[i] = '0;
                            end
                            n_state = ST_SEARCH;
                        end else begin
                            n_fill = r_fill + DEP_W'(1);
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (!at_leaf) begin
                    n_lvl_st[r_lvl]                = node_res;
                    n_lvl                          = r_lvl + LVL_W'(1);
                    n_code[r_lvl + LVL_W'(1)]      = '0;
                end else begin
                    if (node_res.err < r_best_err) begin
                        n_best_err  = node_res.err;
                        n_best_code = r_code;
                        n_best_pred = node_res.pred;
                        n_best_step = node_res.step;
                    end
                    if (r_code[r_lvl] != CODE_MAX) begin
                        n_code[r_lvl] = r_code[r_lvl] + CODE_W'(1);
                    end else if (bt_found) begin
                        n_lvl          = bt_lvl;
                        n_code[bt_lvl] = r_code[bt_lvl] + CODE_W'(1);
                    end else begin
                        n_pred   = n_best_pred;
                        n_step   = n_best_step;
                        n_emit_k = '0;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_val  = {4'd0, r_best_code[r_emit_k]};
                    n_hdr  = 1'b0;
                    n_last = emit_last;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_k = r_emit_k + LVL_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_depth <= 3'd2;
            r_pred  <= 8'd0;
            r_step  <= 4'd1;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_pred  <= n_pred;
            r_step  <= n_step;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dep       <= n_dep;
        r_lvl       <= n_lvl;
        r_emit_k    <= n_emit_k;
        r_samples   <= n_samples;
        r_code      <= n_code;
        r_lvl_st    <= n_lvl_st;
        r_best_code <= n_best_code;
        r_best_err  <= n_best_err;
        r_best_pred <= n_best_pred;
        r_best_step <= n_best_step;
        r_val       <= n_val;
        r_hdr       <= n_hdr;
        r_last      <= n_last;
    end

endmodule

// File: sv/a4ls_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the ADPCM look-ahead search encoder, bound to the top level.
// Depends on adpcm4_lookahead_search_encoder_unit.
module a4ls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_first,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_value,
    input logic       o_is_header,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value))
        else $error("stalled result request changed");

    a_hdr_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_first |=> o_out_valid && o_is_header && o_last)
        else $error("header request not presented on the next cycle");

    a_code_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_header |-> o_value[7:4] == 4'h0)
        else $error("code result wider than four bits");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind adpcm4_lookahead_search_encoder_unit a4ls_checker u_a4ls_checker (.*);
